/* rtl/osdg_pkg.sv */
// ----------------------------------------------------------------------------
// osdg_pkg
// shared constants and command codes for the double buffered osd char grid
// ----------------------------------------------------------------------------
`default_nettype none

package osdg_pkg;

    localparam int unsigned GRID_ROWS_DEF  = 32;
    localparam int unsigned GRID_COLS_DEF  = 64;
    localparam int unsigned MAX_STRING_DEF = 30;

    localparam int unsigned GLYPH_W = 10;
    localparam int unsigned LEFT_W  = 5;

    // message header overhead in the length field
    localparam logic [7:0] LEN_HDR     = 8'd3;
    localparam logic [7:0] LEN_MIN     = 8'd4;
    localparam logic [1:0] ATTR_BAD    = 2'd3;
    localparam logic [1:0] ATTR_SUBST  = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_CLEAR   = 3'd1,
        CMD_STRING  = 3'd2,
        CMD_PUBLISH = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/osdg_ram.sv */
// ----------------------------------------------------------------------------
// osdg_ram
// glyph store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module osdg_ram
    import osdg_pkg::*;
#(
    parameter int unsigned DEPTH  = GRID_ROWS_DEF * GRID_COLS_DEF,
    parameter int unsigned ADDR_W = 11,
    parameter int unsigned DATA_W = GLYPH_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/osd_double_buffered_char_grid_top.sv */
// ----------------------------------------------------------------------------
// osd_double_buffered_char_grid_top
// osd character grid with a back store for drawing and a front store for reads
// ----------------------------------------------------------------------------
// results: string character, clear, publish and ignored commands register their
//   result in the cycle after the item is taken; a read passes through S_READ
// items: string characters can be taken back to back while the result is not
//   stalled; a read, clear or publish holds off the next item until it is done,
//   clear and publish walking each store's single write port one cell per cycle
// reset: synchronous active low; afterwards both stores are zeroed in a pass
//   over every cell during which no item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module osd_double_buffered_char_grid_top
    import osdg_pkg::*;
#(
    parameter int unsigned GRID_ROWS  = GRID_ROWS_DEF,
    parameter int unsigned GRID_COLS  = GRID_COLS_DEF,
    parameter int unsigned MAX_STRING = MAX_STRING_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic               i_first,
    input  wire logic [7:0]         i_payload_len,
    input  wire logic [7:0]         i_row,
    input  wire logic [7:0]         i_col,
    input  wire logic [7:0]         i_attribute,
    input  wire logic [7:0]         i_char_code,
    // result item channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [GLYPH_W-1:0]      o_glyph,
    output logic                    o_wrote,
    output logic                    o_stopped
);

    // grid geometry
    localparam int unsigned CELLS  = GRID_ROWS * GRID_COLS;
    localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [8:0]  ROWS_C = 9'(GRID_ROWS);
    localparam logic [8:0]  COLS_C = 9'(GRID_COLS);
    localparam logic [15:0] COLS_M = 16'(GRID_COLS);
    localparam logic [7:0]  MAX_C  = 8'(MAX_STRING);

    // control sequencer, one-hot
    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,   // zero both stores after reset
        S_IDLE  = 6'b000010,
        S_CLEAR = 6'b000100,   // zero the back store
        S_PUB   = 6'b001000,   // walk back store reads
        S_DRAIN = 6'b010000,   // last front store write of a publish
        S_READ  = 6'b100000    // front store data arrives
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_sweep, n_sweep;

    // publish copy pipeline: read of back store, then write of front store
    logic              r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0] r_cp_addr, n_cp_addr;

    // read command tracking
    logic r_rd_hit, n_rd_hit;

    // string cursor state
    logic [7:0]        r_cur_row, n_cur_row;
    logic [7:0]        r_cur_col, n_cur_col;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [1:0]        r_attr, n_attr;
    logic              r_done, n_done;

    // output register
    logic               r_ov, n_ov;
    logic [GLYPH_W-1:0] r_o_glyph, n_o_glyph;
    logic               r_o_wrote, n_o_wrote;
    logic               r_o_stopped, n_o_stopped;

    // store ports
    logic               w_bk_we, w_fr_we;
    logic [ADDR_W-1:0]  w_bk_waddr, w_fr_waddr;
    logic [GLYPH_W-1:0] w_bk_wdata, w_fr_wdata;
    logic [GLYPH_W-1:0] w_bk_rdata, w_fr_rdata;
    logic [ADDR_W-1:0]  w_addr;

    logic w_acc;
    logic w_slot_free;

    // cell address: a read and a string's first character use the item's
    // row and column, later characters use the cursor
    logic        w_sel_in;
    logic [7:0]  w_row, w_col;
    logic [15:0] w_idx;
    logic        w_hit;

    assign w_sel_in = (i_command == CMD_READ) || i_first;
    assign w_row    = w_sel_in ? i_row : r_cur_row;
    assign w_col    = w_sel_in ? i_col : r_cur_col;
    assign w_idx    = 16'(w_row) * COLS_M + 16'(w_col);
    assign w_addr   = w_idx[ADDR_W-1:0];
    assign w_hit    = ({1'b0, w_row} < ROWS_C) && ({1'b0, w_col} < COLS_C);

    // a new item needs the output register free by the same edge
    assign w_slot_free = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_acc       = i_in_valid && o_in_ready;

    // string character evaluation
    logic [1:0]        s_attr;
    logic [7:0]        s_diff;
    logic [LEFT_W-1:0] s_budget;
    logic [LEFT_W-1:0] s_left_e;
    logic              s_done_e;
    logic [7:0]        s_col_inc, s_row_inc;
    logic              s_wrote, s_stop;

    always_comb begin
        s_attr   = (i_attribute[1:0] == ATTR_BAD) ? ATTR_SUBST : i_attribute[1:0];
        s_diff   = i_payload_len - LEN_HDR;
        s_budget = '0;
        if (i_payload_len >= LEN_MIN) begin
            s_budget = (s_diff > MAX_C) ? LEFT_W'(MAX_C) : s_diff[LEFT_W-1:0];
        end

        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_left    = r_left;
        n_attr    = r_attr;
        n_done    = r_done;
        s_left_e  = r_left;
        s_done_e  = r_done;
        s_wrote   = 1'b0;
        s_stop    = 1'b0;
        s_col_inc = w_col + 8'd1;
        s_row_inc = w_row + 8'd1;

        // first character reloads the cursor, attribute and budget
        if (i_first) begin
            n_cur_row = i_row;
            n_cur_col = i_col;
            n_attr    = s_attr;
            n_left    = s_budget;
            n_done    = 1'b0;
            s_left_e  = s_budget;
            s_done_e  = 1'b0;
        end

        if (s_done_e || (s_left_e == '0) || (i_char_code == 8'd0)) begin
            // closed string, budget gone or zero byte
            n_done = 1'b1;
            s_stop = 1'b1;
        end else begin
            s_wrote = w_hit;
            n_left  = s_left_e - LEFT_W'(1);
            if ({1'b0, s_col_inc} >= COLS_C) begin
                // wrap to the start of the next row
                n_cur_col = 8'd0;
                n_cur_row = s_row_inc;
                if ({1'b0, s_row_inc} >= ROWS_C) begin
                    n_done = 1'b1;
                end
            end else begin
                n_cur_col = s_col_inc;
            end
            if (n_left == '0) begin
                n_done = 1'b1;
            end
            s_stop = n_done;
        end
    end

    // sequencer and store port control
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_cp_valid  = 1'b0;
        n_cp_addr   = r_sweep;
        n_rd_hit    = r_rd_hit;
        n_ov        = r_ov && !i_out_ready;
        n_o_glyph   = r_o_glyph;
        n_o_wrote   = r_o_wrote;
        n_o_stopped = r_o_stopped;

        w_bk_we    = 1'b0;
        w_bk_waddr = r_sweep;
        w_bk_wdata = '0;
        w_fr_we    = r_cp_valid;
        w_fr_waddr = r_cp_addr;
        w_fr_wdata = w_bk_rdata;

        unique case (r_state)
            S_INIT: begin
                // zero both stores one cell per cycle
                w_bk_we    = 1'b1;
                w_fr_we    = 1'b1;
                w_fr_waddr = r_sweep;
                w_fr_wdata = '0;
                if (r_sweep == LAST_CELL) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    // every command but read answers at once
                    n_ov        = (i_command != CMD_READ);
                    n_o_glyph   = '0;
                    n_o_wrote   = 1'b0;
                    n_o_stopped = 1'b0;
                    n_sweep     = '0;
                    n_rd_hit    = w_hit;
                    case (i_command)
                        CMD_CLEAR:   n_state = S_CLEAR;
                        CMD_PUBLISH: n_state = S_PUB;
                        CMD_READ:    n_state = S_READ;
                        CMD_STRING: begin
                            n_o_wrote   = s_wrote;
                            n_o_stopped = s_stop;
                            w_bk_we     = s_wrote;
                            w_bk_waddr  = w_addr;
                            w_bk_wdata  = {n_attr, i_char_code};
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                w_bk_we = 1'b1;
                if (r_sweep == LAST_CELL) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_PUB: begin
                // back store read issued here, front write in the next cycle
                n_cp_valid = 1'b1;
                n_cp_addr  = r_sweep;
                if (r_sweep == LAST_CELL) begin
                    n_sweep = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                // off-grid reads answer zero
                n_ov      = 1'b1;
                n_o_glyph = r_rd_hit ? w_fr_rdata : '0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
                n_sweep = '0;
            end
        endcase
    end

    // commit cursor state only for an accepted string character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_sweep    <= '0;
            r_cp_valid <= 1'b0;
            r_ov       <= 1'b0;
            r_cur_row  <= 8'd0;
            r_cur_col  <= 8'd0;
            r_left     <= '0;
            r_attr     <= 2'd0;
            r_done     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_sweep    <= n_sweep;
            r_cp_valid <= n_cp_valid;
            r_ov       <= n_ov;
            if (w_acc && (i_command == CMD_STRING)) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
                r_left    <= n_left;
                r_attr    <= n_attr;
                r_done    <= n_done;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cp_addr   <= n_cp_addr;
        r_rd_hit    <= n_rd_hit;
        r_o_glyph   <= n_o_glyph;
        r_o_wrote   <= n_o_wrote;
        r_o_stopped <= n_o_stopped;
    end

    // back store: drawn by strings, zeroed by clear, read by publish
    osdg_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (GLYPH_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_we    (w_bk_we),
        .i_waddr (w_bk_waddr),
        .i_wdata (w_bk_wdata),
        .i_raddr (r_sweep),
        .o_rdata (w_bk_rdata)
    );

    // front store: filled by publish, read by the read command
    osdg_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (GLYPH_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_we    (w_fr_we),
        .i_waddr (w_fr_waddr),
        .i_wdata (w_fr_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_fr_rdata)
    );

    assign o_out_valid = r_ov;
    assign o_glyph     = r_o_glyph;
    assign o_wrote     = r_o_wrote;
    assign o_stopped   = r_o_stopped;

endmodule

`default_nettype wire

/* rtl/osdg_chk.sv */
// ----------------------------------------------------------------------------
// osdg_chk
// port level checks for the double buffered osd char grid
// ----------------------------------------------------------------------------
`default_nettype none

module osdg_chk
    import osdg_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [2:0]         i_command,
    input wire logic [7:0]         i_char_code,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [GLYPH_W-1:0] o_glyph,
    input wire logic               o_wrote,
    input wire logic               o_stopped
);

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    // a pending result must leave before a new item comes in
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && o_out_valid) |-> i_out_ready)
        else $error("item taken while result blocked");

    // commands other than string and read answer at once with all zero
    a_quiet_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_command != CMD_STRING) && (i_command != CMD_READ)) |=>
        (o_out_valid && (o_glyph == '0) && !o_wrote && !o_stopped))
        else $error("non-drawing command gave nonzero result");

    // a zero byte ends the string and writes nothing
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_command == CMD_STRING) && (i_char_code == 8'd0)) |=>
        (o_out_valid && o_stopped && !o_wrote && (o_glyph == '0)))
        else $error("zero byte did not end string");

    // a read answers only once the front store data has arrived
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_command == CMD_READ)) |=> !o_out_valid ##1 o_out_valid)
        else $error("read result timing wrong");

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_glyph) && $stable(o_wrote) && $stable(o_stopped)))
        else $error("stalled result changed");

endmodule

bind osd_double_buffered_char_grid_top osdg_chk u_osdg_chk (.*);

`default_nettype wire
